>>> rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

   // default geometry
   localparam int SEQ_BITS_DEFAULT     = 3;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int KIND_BITS   = 2;
   localparam int ACTION_BITS = 3;

   // input event kinds
   localparam logic [KIND_BITS-1:0] KIND_PACKET  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FRAME   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CKSUM   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_TIMEOUT = 2'd3;

   // result actions
   localparam logic [ACTION_BITS-1:0] ACT_TRANSMIT = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DELIVER  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STOP     = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_NOTHING  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_REFUSED  = 3'd4;

endpackage

`default_nettype wire

>>> rtl/gbn_ram.sv
`default_nettype none

module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/go_back_n_link_endpoint_core.sv
`default_nettype none

// Go-Back-N link endpoint with a send window of 2^SEQ_BITS - 1 frames. Each event
// (packet from above, frame arrival, checksum error, timeout) is one req transaction;
// its results leave one per rsp transaction, the final one marked by rsp_tlast, and
// every result of one event carries the same window_open flag. An event is accepted
// in ST_IDLE and decided in ST_DECIDE; the decision loads the result of a packet, a
// checksum error, a timeout with nothing outstanding, an in-order delivery or a frame
// arrival that neither delivers nor stops a timer into the output register. The result
// for each stopped timer of a frame arrival is then loaded in ST_STOP, and the result
// for each resent frame of a timeout in ST_RESEND. The sequencer works on one event at
// a time and req_tready is low until its last result has been loaded into the output
// register. Resent payloads come from an outbound buffer RAM with one read port, read
// one frame per cycle in sequence order while the output register is free.
module go_back_n_link_endpoint_core #(
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((PAYLOAD_BITS + 2 * SEQ_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((PAYLOAD_BITS + 2 * SEQ_BITS + 1 + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // payload, frame_seq, frame_ack (zero padded)
   input  wire logic [REQ_DATA_BITS-1:0]         req_tdata,
   // kind
   input  wire logic [gbn_pkg::KIND_BITS-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_seq, out_ack, out_payload, window_open (zero padded)
   output logic      [RSP_DATA_BITS-1:0]         rsp_tdata,
   // action
   output logic      [gbn_pkg::ACTION_BITS-1:0]  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int                SEQ_COUNT = 1 << SEQ_BITS;
   localparam logic [SEQ_BITS-1:0] WIN     = {SEQ_BITS{1'b1}};
   localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_STOP,
      ST_RESEND
   } state_type;

   // sequencer and window state
   state_type                        state_ff, state_in;
   logic [gbn_pkg::KIND_BITS-1:0]    kind_ff, kind_in;
   logic [PAYLOAD_BITS-1:0]          payload_ff, payload_in;
   logic [SEQ_BITS-1:0]              fseq_ff, fseq_in;
   logic [SEQ_BITS-1:0]              fack_ff, fack_in;
   logic [SEQ_BITS-1:0]              send_next_ff, send_next_in;
   logic [SEQ_BITS-1:0]              oldest_ff, oldest_in;
   logic [SEQ_BITS-1:0]              expected_ff, expected_in;
   logic [SEQ_BITS-1:0]              count_ff, count_in;
   logic [SEQ_BITS-1:0]              remain_ff, remain_in;
   logic                             wopen_ff, wopen_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [gbn_pkg::ACTION_BITS-1:0]  rsp_action_ff, rsp_action_in;
   logic [SEQ_BITS-1:0]              rsp_seq_ff, rsp_seq_in;
   logic [SEQ_BITS-1:0]              rsp_ack_ff, rsp_ack_in;
   logic [PAYLOAD_BITS-1:0]          rsp_payload_ff, rsp_payload_in;
   logic                             rsp_wopen_ff, rsp_wopen_in;
   logic                             rsp_last_ff, rsp_last_in;

   // buffer port
   logic                             buf_wr_en;
   logic [PAYLOAD_BITS-1:0]          buf_rd_data;

   // arithmetic on the window edges
   logic                             slot_free;
   logic [SEQ_BITS-1:0]              ack_dist;
   logic                             ack_hit;
   logic [SEQ_BITS-1:0]              stops;
   logic [SEQ_BITS-1:0]              count_after;
   logic [SEQ_BITS-1:0]              ack_out;
   logic                             in_order;

   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign ack_dist    = fack_ff - oldest_ff;
   assign ack_hit     = ack_dist < count_ff;
   assign stops       = ack_hit ? (ack_dist + SEQ_ONE) : '0;
   assign count_after = count_ff - stops;
   assign ack_out     = expected_ff - SEQ_ONE;
   assign in_order    = fseq_ff == expected_ff;

   // outbound buffer: written on send, read at the next send position
   gbn_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_COUNT)
   ) u_outbound (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (send_next_ff),
      .wr_data (payload_ff),
      .rd_addr (send_next_in),
      .rd_data (buf_rd_data)
   );

   // sequencer next state and result generation
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      payload_in     = payload_ff;
      fseq_in        = fseq_ff;
      fack_in        = fack_ff;
      send_next_in   = send_next_ff;
      oldest_in      = oldest_ff;
      expected_in    = expected_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      wopen_in       = wopen_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_action_in  = rsp_action_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_ack_in     = rsp_ack_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_wopen_in   = rsp_wopen_ff;
      rsp_last_in    = rsp_last_ff;
      buf_wr_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // capture the event
            if (req_tvalid) begin
               kind_in    = req_tuser;
               payload_in = req_tdata[PAYLOAD_BITS-1:0];
               fseq_in    = req_tdata[PAYLOAD_BITS +: SEQ_BITS];
               fack_in    = req_tdata[PAYLOAD_BITS + SEQ_BITS +: SEQ_BITS];
               state_in   = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (slot_free) begin
               rsp_seq_in     = '0;
               rsp_ack_in     = '0;
               rsp_payload_in = '0;
               rsp_last_in    = 1'b1;
               rsp_wopen_in   = count_ff != WIN;
               state_in       = ST_IDLE;
               case (kind_ff)
                  gbn_pkg::KIND_PACKET: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == WIN) begin
                        rsp_action_in = gbn_pkg::ACT_REFUSED;
                     end else begin
                        // store and send at once
                        buf_wr_en      = 1'b1;
                        rsp_action_in  = gbn_pkg::ACT_TRANSMIT;
                        rsp_seq_in     = send_next_ff;
                        rsp_ack_in     = ack_out;
                        rsp_payload_in = payload_ff;
                        rsp_wopen_in   = (count_ff + SEQ_ONE) != WIN;
                        send_next_in   = send_next_ff + SEQ_ONE;
                        count_in       = count_ff + SEQ_ONE;
                     end
                  end
                  gbn_pkg::KIND_FRAME: begin
                     wopen_in     = count_after != WIN;
                     rsp_wopen_in = count_after != WIN;
                     remain_in    = stops;
                     if (in_order) begin
                        rsp_valid_in   = 1'b1;
                        rsp_action_in  = gbn_pkg::ACT_DELIVER;
                        rsp_payload_in = payload_ff;
                        rsp_last_in    = !ack_hit;
                        expected_in    = expected_ff + SEQ_ONE;
                     end else if (!ack_hit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = gbn_pkg::ACT_NOTHING;
                     end
                     if (ack_hit) begin
                        state_in = ST_STOP;
                     end
                  end
                  gbn_pkg::KIND_TIMEOUT: begin
                     // rewind to the oldest unacked frame
                     send_next_in = oldest_ff;
                     wopen_in     = count_ff != WIN;
                     remain_in    = count_ff;
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = gbn_pkg::ACT_NOTHING;
                     end else begin
                        state_in = ST_RESEND;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = gbn_pkg::ACT_NOTHING;
                  end
               endcase
            end
         end

         ST_STOP: begin
            // one cumulative ack step per result
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = gbn_pkg::ACT_STOP;
               rsp_seq_in     = oldest_ff;
               rsp_ack_in     = '0;
               rsp_payload_in = '0;
               rsp_wopen_in   = wopen_ff;
               rsp_last_in    = remain_ff == SEQ_ONE;
               oldest_in      = oldest_ff + SEQ_ONE;
               count_in       = count_ff - SEQ_ONE;
               remain_in      = remain_ff - SEQ_ONE;
               if (remain_ff == SEQ_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_RESEND: begin
            // buffer read data follows send_next
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = gbn_pkg::ACT_TRANSMIT;
               rsp_seq_in     = send_next_ff;
               rsp_ack_in     = ack_out;
               rsp_payload_in = buf_rd_data;
               rsp_wopen_in   = wopen_ff;
               rsp_last_in    = remain_ff == SEQ_ONE;
               send_next_in   = send_next_ff + SEQ_ONE;
               remain_in      = remain_ff - SEQ_ONE;
               if (remain_ff == SEQ_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         send_next_ff <= '0;
         oldest_ff    <= '0;
         expected_ff  <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         send_next_ff <= send_next_in;
         oldest_ff    <= oldest_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      payload_ff     <= payload_in;
      fseq_ff        <= fseq_in;
      fack_ff        <= fack_in;
      wopen_ff       <= wopen_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_ack_ff     <= rsp_ack_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_wopen_ff   <= rsp_wopen_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // port packing
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_wopen_ff, rsp_payload_ff, rsp_ack_ff, rsp_seq_ff});

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int SEQ_W = gbn_pkg::SEQ_BITS_DEFAULT;
   localparam int PAY_W = gbn_pkg::PAYLOAD_BITS_DEFAULT;
   localparam int KIND_W = gbn_pkg::KIND_BITS;
   localparam int ACT_W = gbn_pkg::ACTION_BITS;
   localparam int REQ_W = ((PAY_W + 2 * SEQ_W + 7) / 8) * 8;
   localparam int RSP_W = ((PAY_W + 2 * SEQ_W + 1 + 7) / 8) * 8;
   localparam int SEQ_SPAN = 1 << SEQ_W;
   localparam logic [SEQ_W-1:0] WINDOW = SEQ_W'(SEQ_SPAN - 1);
   localparam int MAX_RESULTS = 8;
   localparam int RANDOM_EVENTS = 151;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int HOLD_OFF_AFTER = 60;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   // one event offered to the endpoint
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [PAY_W-1:0]     payload;
      logic [SEQ_W-1:0]     fseq;
      logic [SEQ_W-1:0]     fack;
      logic                 drain;   // wait for all results before offering
   } link_event_type;

   // one result leaving the endpoint
   typedef struct packed {
      logic [ACT_W-1:0]       action;
      logic [SEQ_W-1:0]       seq;
      logic [SEQ_W-1:0]       ack;
      logic [PAY_W-1:0]       payload;
      logic                   wopen;
      logic                   last;
   } link_result_type;

   // sender and receiver state of one endpoint
   typedef struct packed {
      logic [SEQ_W-1:0]                send_next;
      logic [SEQ_W-1:0]                oldest;
      logic [SEQ_W-1:0]                expected;
      logic [SEQ_W-1:0]                count;
      logic [SEQ_SPAN-1:0][PAY_W-1:0]  store;
   } link_state_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [ACT_W-1:0]  rsp_tuser;
   logic              rsp_tlast;

   link_event_type  pending_events [$];
   link_result_type expected_results [$];
   link_state_type  peer_view;
   link_state_type  endpoint_view;
   int           results_due = 0;
   int           fail_count = 0;
   int           send_gap = 0;
   int           hold_left = 0;
   int           taken_count = 0;
   bit           held_long = 1'b0;
   int           idle_cycles = 0;

   go_back_n_link_endpoint_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // lo <= x < hi on the sequence circle
   function automatic bit seq_between(input logic [SEQ_W-1:0] lo, x, hi);
      return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
             ((x < hi) && (hi < lo));
   endfunction

   // advance the endpoint by one event, returning the number of results
   function automatic int link_step(inout link_state_type s, input link_event_type e,
                                    output link_result_type r [MAX_RESULTS]);
      int n;
      int c;
      n = 0;
      for (int i = 0; i < MAX_RESULTS; i++) r[i] = '0;
      case (e.kind)
         gbn_pkg::KIND_PACKET: begin
            if (s.count >= WINDOW) begin
               r[n].action = gbn_pkg::ACT_REFUSED;
               n++;
            end else begin
               s.store[s.send_next] = e.payload;
               s.count = s.count + 1'b1;
               r[n].action = gbn_pkg::ACT_TRANSMIT;
               r[n].seq = s.send_next;
               r[n].ack = s.expected + WINDOW;
               r[n].payload = s.store[s.send_next];
               n++;
               s.send_next = s.send_next + 1'b1;
            end
         end
         gbn_pkg::KIND_FRAME: begin
            // in-order payload goes up, ack is taken either way
            if (e.fseq == s.expected) begin
               r[n].action = gbn_pkg::ACT_DELIVER;
               r[n].payload = e.payload;
               n++;
               s.expected = s.expected + 1'b1;
            end
            while (s.count > 0 && seq_between(s.oldest, e.fack, s.send_next)) begin
               s.count = s.count - 1'b1;
               r[n].action = gbn_pkg::ACT_STOP;
               r[n].seq = s.oldest;
               n++;
               s.oldest = s.oldest + 1'b1;
            end
         end
         gbn_pkg::KIND_TIMEOUT: begin
            // go back to the oldest frame and resend the lot
            s.send_next = s.oldest;
            for (c = 0; c < s.count; c++) begin
               r[n].action = gbn_pkg::ACT_TRANSMIT;
               r[n].seq = s.send_next;
               r[n].ack = s.expected + WINDOW;
               r[n].payload = s.store[s.send_next];
               n++;
               s.send_next = s.send_next + 1'b1;
            end
         end
         default: ;
      endcase
      if (n == 0) begin
         r[n].action = gbn_pkg::ACT_NOTHING;
         n++;
      end
      for (int i = 0; i < n; i++) begin
         r[i].wopen = (s.count < WINDOW);
         r[i].last = (i == n - 1);
      end
      return n;
   endfunction

   // queue an event and track what the peer will see
   task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [PAY_W-1:0] pay,
                              input logic [SEQ_W-1:0] fseq, fack, input bit drain);
      link_event_type  e;
      link_result_type scratch [MAX_RESULTS];
      e.kind = kind;
      e.payload = pay;
      e.fseq = fseq;
      e.fack = fack;
      e.drain = drain;
      pending_events.push_back(e);
      void'(link_step(peer_view, e, scratch));
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   // length of an idle stretch: mostly none or short, now and then long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // stimulus and end of run
   initial begin
      int                pick;
      logic [PAY_W-1:0]  pay;
      logic [SEQ_W-1:0]  fseq;
      logic [SEQ_W-1:0]  fack;
      bit                drain;

      peer_view = '0;
      endpoint_view = '0;

      // directed: idle events, fill the window, refuse, resend, ack everything
      queue_event(gbn_pkg::KIND_CKSUM, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b0);
      queue_event(gbn_pkg::KIND_TIMEOUT, 32'h0, 3'd0, 3'd0, 1'b0);
      queue_event(gbn_pkg::KIND_FRAME, 32'h0, 3'd0, 3'd7, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h0000_0000, 3'd0, 3'd0, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'hA5A5_A5A5, 3'd5, 3'd2, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h5A5A_5A5A, 3'd2, 3'd5, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h8000_0001, 3'd1, 3'd6, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h7FFF_FFFE, 3'd6, 3'd1, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h0F0F_F0F0, 3'd3, 3'd4, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'h1234_5678, 3'd4, 3'd3, 1'b0);
      queue_event(gbn_pkg::KIND_TIMEOUT, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b0);
      // out-of-order frame with an ack beyond the send edge
      queue_event(gbn_pkg::KIND_FRAME, 32'hDEAD_BEEF, 3'd7, 3'd7, 1'b0);
      // in order frame acking the whole window
      queue_event(gbn_pkg::KIND_FRAME, 32'hFFFF_FFFF, 3'd1, 3'd6, 1'b0);
      queue_event(gbn_pkg::KIND_PACKET, 32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0);
      queue_event(gbn_pkg::KIND_FRAME, 32'h0000_0000, 3'd3, 3'd7, 1'b0);
      // stale ack with nothing outstanding
      queue_event(gbn_pkg::KIND_FRAME, 32'hFFFF_FFFF, 3'd2, 3'd0, 1'b0);
      queue_event(gbn_pkg::KIND_FRAME, 32'h1357_9BDF, 3'd0, 3'd3, 1'b0);
      queue_event(gbn_pkg::KIND_CKSUM, 32'h0, 3'd0, 3'd0, 1'b0);

      // random: mostly well-formed traffic from the peer, some noise
      for (int k = 0; k < RANDOM_EVENTS; k++) begin
         pick = $urandom_range(0, 99);
         pay = $urandom;
         fseq = SEQ_W'($urandom_range(0, SEQ_SPAN - 1));
         fack = SEQ_W'($urandom_range(0, SEQ_SPAN - 1));
         drain = (k == 0) || ($urandom_range(0, 49) == 0);
         if (pick < 35) begin
            queue_event(gbn_pkg::KIND_PACKET, pay, fseq, fack, drain);
         end else if (pick < 75) begin
            if ($urandom_range(0, 3) != 0) fseq = peer_view.expected;
            if (peer_view.count > 0 && $urandom_range(0, 9) < 7)
               fack = peer_view.oldest + SEQ_W'($urandom_range(0, peer_view.count - 1));
            queue_event(gbn_pkg::KIND_FRAME, pay, fseq, fack, drain);
         end else if (pick < 85) begin
            queue_event(gbn_pkg::KIND_CKSUM, pay, fseq, fack, drain);
         end else begin
            queue_event(gbn_pkg::KIND_TIMEOUT, pay, fseq, fack, drain);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait for the last transaction, then let the block settle
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || results_due != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("** go_back_n_link_endpoint_core: PASSED **");
      end else begin
         $display("** go_back_n_link_endpoint_core: FAILED **");
      end
      $finish;
   end

   // driver: offers queued events with random gaps
   always @(posedge clock) begin
      link_event_type nxt;
      bit          fire;
      bit          offer;
      fire = req_tvalid && req_tready;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (fire || !req_tvalid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_events.size() != 0) begin
            // a draining event waits until every result has come back
            if (!pending_events[0].drain || (!fire && results_due == 0)) offer = 1'b1;
         end
         if (offer) begin
            nxt = pending_events.pop_front();
            req_tdata <= REQ_W'({nxt.fack, nxt.fseq, nxt.payload});
            req_tuser <= nxt.kind;
            send_gap <= pick_gap();
         end
         req_tvalid <= offer;
      end
   end

   // monitor: predicts on each accepted event, checks each accepted result
   always @(posedge clock) begin
      link_event_type  got_evt;
      link_result_type batch [MAX_RESULTS];
      link_result_type want;
      link_result_type seen;
      int           n;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            got_evt.kind = req_tuser;
            got_evt.payload = req_tdata[PAY_W-1:0];
            got_evt.fseq = req_tdata[PAY_W +: SEQ_W];
            got_evt.fack = req_tdata[PAY_W + SEQ_W +: SEQ_W];
            got_evt.drain = 1'b0;
            n = link_step(endpoint_view, got_evt, batch);
            for (int i = 0; i < n; i++) expected_results.push_back(batch[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.action = rsp_tuser;
            seen.seq = rsp_tdata[SEQ_W-1:0];
            seen.ack = rsp_tdata[SEQ_W +: SEQ_W];
            seen.payload = rsp_tdata[2 * SEQ_W +: PAY_W];
            seen.wopen = rsp_tdata[2 * SEQ_W + PAY_W];
            seen.last = rsp_tlast;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result action %0d seq %0d payload %h",
                                      seen.action, seen.seq, seen.payload));
            end else begin
               want = expected_results.pop_front();
               if (seen.action !== want.action || seen.seq !== want.seq ||
                   seen.ack !== want.ack || seen.payload !== want.payload ||
                   seen.wopen !== want.wopen || seen.last !== want.last)
                  note_failure($sformatf({"mismatch: expected act %0d seq %0d ack %0d ",
                     "pay %h open %0b last %0b, got act %0d seq %0d ack %0d pay %h ",
                     "open %0b last %0b"},
                     want.action, want.seq, want.ack, want.payload, want.wopen, want.last,
                     seen.action, seen.seq, seen.ack, seen.payload, seen.wopen, seen.last));
            end
         end
         results_due <= expected_results.size();
      end
   end

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      int p;
      if (rsp_tvalid && rsp_tready) taken_count++;
      p = $urandom_range(0, 99);
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!held_long && taken_count >= HOLD_OFF_AFTER) begin
         held_long <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (p < 70) begin
         rsp_tready <= 1'b1;
      end else if (p < 95) begin
         hold_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         hold_left <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** go_back_n_link_endpoint_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> go_back_n_link_endpoint_core.f
rtl/gbn_pkg.sv
rtl/gbn_ram.sv
rtl/go_back_n_link_endpoint_core.sv
dv/tb_top.sv
